### rtl/imu_dfr_pkg.sv
// Shared constants and types for the IMU frame deframer.
// Used by imu_dfr_parse and imu_frame_deframer_unit; no dependencies.
`timescale 1ns / 1ps

package imu_dfr_pkg;

    // Frame layout
    localparam int PosBits   = 5;
    localparam int WordBits  = 16;
    localparam int NumWords  = 10;
    localparam int IdxBits   = 4;
    localparam int SumBits   = 13;

    localparam logic [PosBits-1:0] PosHunt       = 5'd0;
    localparam logic [PosBits-1:0] PosHdr1       = 5'd1;
    localparam logic [PosBits-1:0] PosFirstSum   = 5'd2;
    localparam logic [PosBits-1:0] PosFirstField = 5'd6;
    localparam logic [PosBits-1:0] PosLastSum    = 5'd25;
    localparam logic [PosBits-1:0] PosCksumLo    = 5'd26;
    localparam logic [PosBits-1:0] PosCksumHi    = 5'd27;
    localparam logic [PosBits-1:0] PosTail0      = 5'd28;
    localparam logic [PosBits-1:0] PosTail1      = 5'd29;
    localparam logic [PosBits-1:0] FrameLen      = 5'd30;

    // Word index of a field = position[4:1] - WordIdxBase
    localparam logic [IdxBits-1:0] WordIdxBase = 4'd3;

    // Marker bytes
    localparam logic [7:0] Hdr0  = 8'h80;
    localparam logic [7:0] Hdr1  = 8'h01;
    localparam logic [7:0] Tail0 = 8'h0D;
    localparam logic [7:0] Tail1 = 8'h0A;

    localparam logic [WordBits-1:0] BadMax = 16'hFFFF;

    // One decoded frame
    typedef logic [NumWords-1:0][WordBits-1:0] t_words;

    typedef struct packed {
        t_words              words;
        logic                checksum_ok;
        logic [WordBits-1:0] bad_frames;
    } t_result;

endpackage

### rtl/imu_dfr_parse.sv
// Byte-level frame parser: header hunt, field assembly, checksum and bad-frame count.
// Depends on imu_dfr_pkg.
`timescale 1ns / 1ps

module imu_dfr_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output logic                  o_res_valid,
    output imu_dfr_pkg::t_result  o_res
);

    logic [imu_dfr_pkg::PosBits-1:0]  r_pos, n_pos, pos_eff;
    logic [7:0]                       r_held, n_held;
    logic [imu_dfr_pkg::SumBits-1:0]  r_sum, n_sum;
    logic [imu_dfr_pkg::WordBits-1:0] r_cksum, n_cksum;
    logic [imu_dfr_pkg::WordBits-1:0] r_bad, n_bad;
    imu_dfr_pkg::t_words              r_words;
    logic                             wr_en;
    logic [imu_dfr_pkg::IdxBits-1:0]  wr_idx;
    logic                             sum_ok;

    // Out-of-range position falls back to hunting
    assign pos_eff = (r_pos >= imu_dfr_pkg::FrameLen) ? imu_dfr_pkg::PosHunt : r_pos;
    assign wr_idx  = pos_eff[imu_dfr_pkg::PosBits-1:1] - imu_dfr_pkg::WordIdxBase;
    assign sum_ok  = ({{(imu_dfr_pkg::WordBits-imu_dfr_pkg::SumBits){1'b0}}, r_sum}
                      == r_cksum);

    // Next-state decode for one byte
    always_comb begin
        n_pos       = pos_eff;
        n_held      = r_held;
        n_sum       = r_sum;
        n_cksum     = r_cksum;
        n_bad       = r_bad;
        wr_en       = 1'b0;
        o_res_valid = 1'b0;
        if (pos_eff == imu_dfr_pkg::PosHunt) begin
            n_pos = (i_byte == imu_dfr_pkg::Hdr0) ? imu_dfr_pkg::PosHdr1
                                                  : imu_dfr_pkg::PosHunt;
        end else if (pos_eff == imu_dfr_pkg::PosHdr1) begin
            if (i_byte == imu_dfr_pkg::Hdr1) begin
                n_sum = '0;
                n_pos = imu_dfr_pkg::PosFirstSum;
            end else begin
                // a repeated 0x80 may start the real header
                n_pos = (i_byte == imu_dfr_pkg::Hdr0) ? imu_dfr_pkg::PosHdr1
                                                      : imu_dfr_pkg::PosHunt;
            end
        end else if (pos_eff inside {[imu_dfr_pkg::PosFirstSum:imu_dfr_pkg::PosLastSum]}) begin
            n_sum = r_sum + {{(imu_dfr_pkg::SumBits-8){1'b0}}, i_byte};
            if (pos_eff >= imu_dfr_pkg::PosFirstField) begin
                if (!pos_eff[0]) begin
                    n_held = i_byte;
                end else begin
                    wr_en = 1'b1;
                end
            end
            n_pos = pos_eff + 1'b1;
        end else if (pos_eff == imu_dfr_pkg::PosCksumLo) begin
            n_cksum = {r_cksum[15:8], i_byte};
            n_pos   = imu_dfr_pkg::PosCksumHi;
        end else if (pos_eff == imu_dfr_pkg::PosCksumHi) begin
            n_cksum = {i_byte, r_cksum[7:0]};
            n_pos   = imu_dfr_pkg::PosTail0;
        end else if (pos_eff == imu_dfr_pkg::PosTail0) begin
            n_pos = (i_byte == imu_dfr_pkg::Tail0) ? imu_dfr_pkg::PosTail1
                                                   : imu_dfr_pkg::PosHunt;
        end else begin
            // last tail byte: frame done either way
            n_pos = imu_dfr_pkg::PosHunt;
            if (i_byte == imu_dfr_pkg::Tail1) begin
                o_res_valid = 1'b1;
                if (!sum_ok && r_bad != imu_dfr_pkg::BadMax) begin
                    n_bad = r_bad + 1'b1;
                end
            end
        end
    end

    // Result payload, valid only with o_res_valid
    always_comb begin
        o_res.words       = r_words;
        o_res.checksum_ok = sum_ok;
        o_res.bad_frames  = n_bad;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= imu_dfr_pkg::PosHunt;
            r_held  <= '0;
            r_sum   <= '0;
            r_cksum <= '0;
            r_bad   <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_held  <= n_held;
            r_sum   <= n_sum;
            r_cksum <= n_cksum;
            r_bad   <= n_bad;
        end
    end

    // Field words, one written per odd position
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < imu_dfr_pkg::NumWords; k++) begin
            if (i_step && wr_en && wr_idx == imu_dfr_pkg::IdxBits'(k)) begin
                r_words[k] <= {i_byte, r_held};
            end
        end
    end

endmodule

### rtl/imu_frame_deframer_unit.sv
// IMU frame deframer top level: input register, parser, result register.
// Depends on imu_dfr_pkg and imu_dfr_parse.
`timescale 1ns / 1ps

// Usage
//   Input channel: one received serial byte per transfer on i_rx_byte
//   (i_in_valid / o_in_stall). Output channel: one decoded frame per
//   transfer (o_out_valid / i_out_stall) carrying ten signed raw words,
//   the checksum flag and the saturating bad-frame count.
//   A byte is captured in the input register, decoded by single-pass logic
//   and, when it is the closing tail byte of a frame with both tail bytes
//   right, the result is loaded into the output register, whatever the
//   checksum. Throughput is one byte per cycle unless a finished frame
//   waits on a stalled output register; a frame is 30 bytes, so at most one
//   result per 30 bytes. The rate is set by the one-byte input register.
//   Reset (synchronous, active low) puts the parser in header hunt, clears
//   the bad-frame count and empties both registers.
//   While the receiver stalls with a result pending, bytes that produce no
//   result keep flowing; only a byte that completes another frame waits in
//   the input register, which then stalls the sender.

module imu_frame_deframer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_gyro_x,
    output logic signed [15:0] o_gyro_y,
    output logic signed [15:0] o_gyro_z,
    output logic signed [15:0] o_accel_x,
    output logic signed [15:0] o_accel_y,
    output logic signed [15:0] o_accel_z,
    output logic signed [15:0] o_pitch_raw,
    output logic signed [15:0] o_roll_raw,
    output logic signed [15:0] o_yaw_raw,
    output logic signed [15:0] o_temperature_raw,
    output logic               o_checksum_ok,
    output logic [15:0]        o_bad_frames
);

    logic                 r_in_valid, n_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_out_valid, n_out_valid;
    imu_dfr_pkg::t_result r_res;
    imu_dfr_pkg::t_result res;
    logic                 res_valid;
    logic                 in_xfer;
    logic                 step;

    // A held byte is decoded unless it would produce a result the output can't take
    assign step       = r_in_valid && (!res_valid || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_xfer    = i_in_valid && !o_in_stall;

    imu_dfr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register
    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (step && res_valid) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_res <= res;
        end
    end

    // Output fields
    assign o_out_valid       = r_out_valid;
    assign o_gyro_x          = r_res.words[0];
    assign o_gyro_y          = r_res.words[1];
    assign o_gyro_z          = r_res.words[2];
    assign o_accel_x         = r_res.words[3];
    assign o_accel_y         = r_res.words[4];
    assign o_accel_z         = r_res.words[5];
    assign o_pitch_raw       = r_res.words[6];
    assign o_roll_raw        = r_res.words[7];
    assign o_yaw_raw         = r_res.words[8];
    assign o_temperature_raw = r_res.words[9];
    assign o_checksum_ok     = r_res.checksum_ok;
    assign o_bad_frames      = r_res.bad_frames;

    // Assertions
    a_bad_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_checksum_ok |-> o_bad_frames != 16'd0)
        else $error("checksum failure reported with zero bad-frame count");

    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input byte lost or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("registers not empty after reset");

endmodule

### test/imu_dfr_checker.sv
// Frame checker for imu_frame_deframer_unit: tracks the byte stream, predicts
// each decoded frame and compares it with the output channel.
// Depends on imu_dfr_pkg.
`timescale 1ns / 1ps

module imu_dfr_checker
    import imu_dfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] o_gyro_x,
    input  logic signed [15:0] o_gyro_y,
    input  logic signed [15:0] o_gyro_z,
    input  logic signed [15:0] o_accel_x,
    input  logic signed [15:0] o_accel_y,
    input  logic signed [15:0] o_accel_z,
    input  logic signed [15:0] o_pitch_raw,
    input  logic signed [15:0] o_roll_raw,
    input  logic signed [15:0] o_yaw_raw,
    input  logic signed [15:0] o_temperature_raw,
    input  logic               o_checksum_ok,
    input  logic [15:0]        o_bad_frames,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Parser shadow state
    logic [PosBits-1:0]  frame_pos;
    logic [7:0]          low_byte;
    logic [SumBits-1:0]  byte_sum;
    logic [WordBits-1:0] cksum_word;
    t_words              frame_words;
    logic [WordBits-1:0] bad_count;

    t_result expected_frames[$];

    string word_names [NumWords] = '{"gyro_x", "gyro_y", "gyro_z", "accel_x", "accel_y",
                                     "accel_z", "pitch_raw", "roll_raw", "yaw_raw",
                                     "temperature_raw"};

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Advance the shadow parser by one received byte; queue a frame on a good tail
    task automatic track_byte(input logic [7:0] b);
        logic [PosBits-1:0] p;
        logic [IdxBits-1:0] idx;
        logic               sum_match;
        t_result            frame;
        p = (frame_pos >= FrameLen) ? PosHunt : frame_pos;
        if (p == PosHunt) begin
            frame_pos = (b == Hdr0) ? PosHdr1 : PosHunt;
        end else if (p == PosHdr1) begin
            if (b == Hdr1) begin
                byte_sum  = '0;
                frame_pos = PosFirstSum;
            end else begin
                // a repeated first header byte restarts the header
                frame_pos = (b == Hdr0) ? PosHdr1 : PosHunt;
            end
        end else if (p <= PosLastSum) begin
            byte_sum = byte_sum + SumBits'(b);
            if (p >= PosFirstField) begin
                if (!p[0]) begin
                    low_byte = b;
                end else begin
                    idx = IdxBits'((p - PosFirstField) >> 1);
                    frame_words[idx] = {b, low_byte};
                end
            end
            frame_pos = p + 1'b1;
        end else if (p == PosCksumLo) begin
            cksum_word[7:0] = b;
            frame_pos = PosCksumHi;
        end else if (p == PosCksumHi) begin
            cksum_word[15:8] = b;
            frame_pos = PosTail0;
        end else if (p == PosTail0) begin
            frame_pos = (b == Tail0) ? PosTail1 : PosHunt;
        end else begin
            frame_pos = PosHunt;
            if (b == Tail1) begin
                // words above the 13-bit sum range never match
                sum_match = (WordBits'(byte_sum) == cksum_word);
                if (!sum_match && bad_count != BadMax)
                    bad_count = bad_count + 1'b1;
                frame.words       = frame_words;
                frame.checksum_ok = sum_match;
                frame.bad_frames  = bad_count;
                expected_frames.push_back(frame);
            end
        end
    endtask

    // Compare one output transfer with the oldest predicted frame
    task automatic check_frame();
        t_words  seen;
        t_result want;
        seen[0] = o_gyro_x;
        seen[1] = o_gyro_y;
        seen[2] = o_gyro_z;
        seen[3] = o_accel_x;
        seen[4] = o_accel_y;
        seen[5] = o_accel_z;
        seen[6] = o_pitch_raw;
        seen[7] = o_roll_raw;
        seen[8] = o_yaw_raw;
        seen[9] = o_temperature_raw;
        if (expected_frames.size() == 0) begin
            $display("%0t: unexpected frame, expected none, got gyro_x %h bad_frames %0d",
                     $time, o_gyro_x, o_bad_frames);
            o_fail_count++;
        end else begin
            want = expected_frames.pop_front();
            for (int k = 0; k < NumWords; k++) begin
                if (seen[k] !== want.words[k]) begin
                    $display("%0t: %s expected %h got %h", $time, word_names[k],
                             want.words[k], seen[k]);
                    o_fail_count++;
                end
            end
            if (o_checksum_ok !== want.checksum_ok) begin
                $display("%0t: checksum_ok expected %b got %b", $time,
                         want.checksum_ok, o_checksum_ok);
                o_fail_count++;
            end
            if (o_bad_frames !== want.bad_frames) begin
                $display("%0t: bad_frames expected %0d got %0d", $time,
                         want.bad_frames, o_bad_frames);
                o_fail_count++;
            end
        end
    endtask

    // Watch both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos   = PosHunt;
            low_byte    = '0;
            byte_sum    = '0;
            cksum_word  = '0;
            frame_words = '0;
            bad_count   = '0;
            expected_frames.delete();
        end else begin
            if (o_out_valid && !i_out_stall)
                check_frame();
            if (i_in_valid && !o_in_stall)
                track_byte(i_rx_byte);
        end
        o_pending = expected_frames.size();
    end

endmodule

### test/tb_imu_frame_deframer_unit.sv
// Testbench top for imu_frame_deframer_unit: drives the serial byte stream and
// receiver stalls, and reports the verdict from imu_dfr_checker.
// Depends on imu_dfr_pkg, imu_dfr_checker and the deframer RTL.
`timescale 1ns / 1ps

module tb_imu_frame_deframer_unit;
    import imu_dfr_pkg::*;

    typedef enum int {
        FrameGood,
        FrameBadSum,
        FrameHighSum,
        FrameBadTail0,
        FrameBadTail1,
        FrameCut
    } t_frame_kind;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_rx_byte   = 8'h00;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [15:0] o_gyro_x, o_gyro_y, o_gyro_z;
    logic signed [15:0] o_accel_x, o_accel_y, o_accel_z;
    logic signed [15:0] o_pitch_raw, o_roll_raw, o_yaw_raw, o_temperature_raw;
    logic               o_checksum_ok;
    logic [15:0]        o_bad_frames;

    int fail_count;
    int pending;
    int bytes_sent   = 0;
    int frames_ended = 0;
    int gap_pct      = 0;
    int stall_left   = 0;
    bit quiet        = 1'b0;

    always #5 i_clk = ~i_clk;

    imu_frame_deframer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_gyro_x          (o_gyro_x),
        .o_gyro_y          (o_gyro_y),
        .o_gyro_z          (o_gyro_z),
        .o_accel_x         (o_accel_x),
        .o_accel_y         (o_accel_y),
        .o_accel_z         (o_accel_z),
        .o_pitch_raw       (o_pitch_raw),
        .o_roll_raw        (o_roll_raw),
        .o_yaw_raw         (o_yaw_raw),
        .o_temperature_raw (o_temperature_raw),
        .o_checksum_ok     (o_checksum_ok),
        .o_bad_frames      (o_bad_frames)
    );

    imu_dfr_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_gyro_x          (o_gyro_x),
        .o_gyro_y          (o_gyro_y),
        .o_gyro_z          (o_gyro_z),
        .o_accel_x         (o_accel_x),
        .o_accel_y         (o_accel_y),
        .o_accel_z         (o_accel_z),
        .o_pitch_raw       (o_pitch_raw),
        .o_roll_raw        (o_roll_raw),
        .o_yaw_raw         (o_yaw_raw),
        .o_temperature_raw (o_temperature_raw),
        .o_checksum_ok     (o_checksum_ok),
        .o_bad_frames      (o_bad_frames),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Receiver stalls in random bursts, none in the final stretch
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 16);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Field word: fixed extremes for the directed frame, else biased random
    function automatic logic [15:0] pick_word(input int k, input bit extremes);
        if (extremes) begin
            case (k)
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'h7FFF;
                3:       return 16'h8000;
                4:       return 16'h0001;
                5:       return 16'h00FF;
                6:       return 16'hFF00;
                7:       return 16'h5555;
                8:       return 16'hAAAA;
                default: return 16'h8001;
            endcase
        end
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One byte transfer, optionally preceded by an idle burst
    task automatic send_byte(input logic [7:0] b);
        int n;
        if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            n = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            i_rx_byte  <= 8'($urandom);
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Build a 30-byte frame of the given kind and send it (or its head only)
    task automatic send_frame(input t_frame_kind kind, input bit extremes);
        logic [7:0]  fb [0:29];
        logic [15:0] w;
        logic [15:0] cks;
        logic [12:0] s;
        int          last;
        fb[0] = Hdr0;
        fb[1] = Hdr1;
        for (int k = 2; k < 6; k++)
            fb[k] = 8'($urandom);
        for (int k = 0; k < NumWords; k++) begin
            w = pick_word(k, extremes);
            fb[6 + 2 * k] = w[7:0];
            fb[7 + 2 * k] = w[15:8];
        end
        s = '0;
        for (int k = 2; k < 26; k++)
            s = s + 13'(fb[k]);
        case (kind)
            FrameBadSum:  cks = {3'b000, s ^ 13'($urandom_range(1, 8191))};
            FrameHighSum: cks = 16'($urandom_range(8192, 65535));
            default:      cks = {3'b000, s};
        endcase
        fb[26] = cks[7:0];
        fb[27] = cks[15:8];
        fb[28] = Tail0;
        fb[29] = Tail1;
        if (kind == FrameBadTail0) begin
            fb[28] = 8'($urandom);
            if (fb[28] == Tail0)
                fb[28] = fb[28] ^ 8'h01;
        end
        if (kind == FrameBadTail1) begin
            fb[29] = 8'($urandom);
            if (fb[29] == Tail1)
                fb[29] = fb[29] ^ 8'h01;
        end
        last = (kind == FrameCut) ? $urandom_range(2, 28) : 29;
        for (int k = 0; k <= last; k++)
            send_byte(fb[k]);
        if (kind == FrameGood || kind == FrameBadSum || kind == FrameHighSum)
            frames_ended++;
    endtask

    // Hold the sender off until every predicted frame has come out
    task automatic drain_frames();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int          r;
        int          n;
        int          frame_cnt;
        t_frame_kind kind;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Header hunting: stray bytes, wrong second byte, repeated first byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(Hdr0);
        send_byte(8'h55);
        send_byte(Hdr0);
        send_frame(FrameGood, 1'b1);
        drain_frames();

        // Random frames, mostly well formed, with noise and broken ones
        frame_cnt = 0;
        while (bytes_sent < 1000 || frames_ended < 34) begin
            if (frame_cnt % 8 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 5;
                    default: gap_pct = 30;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(($urandom_range(0, 3) == 0) ? Hdr0 : 8'($urandom));
            end else begin
                if (r < 55)      kind = FrameGood;
                else if (r < 67) kind = FrameBadSum;
                else if (r < 73) kind = FrameHighSum;
                else if (r < 81) kind = FrameBadTail0;
                else if (r < 89) kind = FrameBadTail1;
                else             kind = FrameCut;
                send_frame(kind, 1'b0);
            end
            frame_cnt++;
            if (frame_cnt % 25 == 0)
                drain_frames();
        end

        // Final stretch at full rate on both sides
        gap_pct = 0;
        quiet <= 1'b1;
        repeat (6) begin
            r = $urandom_range(0, 2);
            kind = (r == 0) ? FrameGood : (r == 1) ? FrameBadSum : FrameHighSum;
            send_frame(kind, 1'b0);
        end
        drain_frames();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/imu_dfr_pkg.sv
rtl/imu_dfr_parse.sv
rtl/imu_frame_deframer_unit.sv
test/imu_dfr_checker.sv
test/tb_imu_frame_deframer_unit.sv
